// ===== rtl/core/spsc_pkg.sv =====
// Shared constants, types and helpers of the stack pop sequence checker.
package spsc_pkg;

   localparam int MAX_LEN = 64;
   localparam int VAL_W   = 7;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = $clog2(MAX_LEN);

   typedef struct packed {
      logic [VAL_W-1:0] element;
      logic             last;
      logic             bad_range;
      logic             count_err;
   } item_type;

   function automatic logic [VAL_W-1:0] eff_len(input logic [VAL_W-1:0] len);
      logic [VAL_W-1:0] res;
      if (int'(len) > MAX_LEN) begin
         res = VAL_W'(MAX_LEN);
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/spsc_front.sv =====
// Front end: length register, range check and element count of each sequence.
module spsc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [spsc_pkg::VAL_W-1:0] req_element,
   input  logic                      req_last,
   input  logic                      csr_wr_en,
   input  logic [spsc_pkg::VAL_W-1:0] csr_wr_data,
   input  logic                      q_full,
   output logic                      q_wr_en,
   output spsc_pkg::item_type        q_wr_item
);

   logic [spsc_pkg::VAL_W-1:0] seq_len_ff;
   logic [spsc_pkg::VAL_W-1:0] seq_len_in;
   logic [spsc_pkg::CNT_W-1:0] seen_ff;
   logic [spsc_pkg::CNT_W-1:0] seen_in;
   logic [spsc_pkg::VAL_W-1:0] n_eff;
   logic [spsc_pkg::CNT_W:0]   seen_plus;

   assign req_full  = q_full;
   assign q_wr_en   = req_push && !q_full;
   assign n_eff     = spsc_pkg::eff_len(seq_len_ff);
   assign seen_plus = {1'b0, seen_ff} + (spsc_pkg::CNT_W + 1)'(1);

   always_comb begin
      q_wr_item.element   = req_element;
      q_wr_item.last      = req_last;
      q_wr_item.bad_range = (req_element == '0) || (req_element > n_eff);
      q_wr_item.count_err = req_last && (seen_plus != (spsc_pkg::CNT_W + 1)'(n_eff));
   end

   always_comb begin
      seq_len_in = csr_wr_en ? csr_wr_data : seq_len_ff;
      seen_in    = seen_ff;
      if (q_wr_en) begin
         if (req_last) begin
            seen_in = '0;
         end else if (int'(seen_ff) < spsc_pkg::MAX_LEN) begin
            seen_in = seen_ff + spsc_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= spsc_pkg::VAL_W'(1);
         seen_ff    <= '0;
      end else begin
         seq_len_ff <= seq_len_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// ===== rtl/core/spsc_fifo.sv =====
// Two-entry queue of classified elements between front and back end.
module spsc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  spsc_pkg::item_type wr_item,
   output logic               full,
   input  logic               rd_en,
   output logic               empty,
   output spsc_pkg::item_type rd_item
);

   spsc_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_wr;
   logic       do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_item = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== rtl/core/spsc_back.sv =====
// Back end: stack engine with top register, stack memory and result register.
module spsc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  spsc_pkg::item_type        q_item,
   output logic                      q_rd_en,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_still_valid,
   output logic                      rsp_done_res,
   output logic                      rsp_count_error
);

   typedef enum logic [1:0] {
      ST_DECIDE,
      ST_PUSH,
      ST_EMIT,
      ST_REFILL
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic [spsc_pkg::ADDR_W-1:0] depth_ff;
   logic [spsc_pkg::ADDR_W-1:0] depth_in;
   logic [spsc_pkg::VAL_W-1:0]  next_ff;
   logic [spsc_pkg::VAL_W-1:0]  next_in;
   logic [spsc_pkg::VAL_W-1:0]  top_ff;
   logic [spsc_pkg::VAL_W-1:0]  top_in;
   logic                        failed_ff;
   logic                        failed_in;
   spsc_pkg::item_type          item_ff;
   spsc_pkg::item_type          item_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        out_still_ff;
   logic                        out_still_in;
   logic                        out_done_ff;
   logic                        out_done_in;
   logic                        out_cerr_ff;
   logic                        out_cerr_in;

   logic [spsc_pkg::VAL_W-1:0]  stack_mem [spsc_pkg::MAX_LEN];
   logic [spsc_pkg::VAL_W-1:0]  rd_data_ff;
   logic [spsc_pkg::ADDR_W-1:0] rd_addr;
   logic                        wr_en;
   logic [spsc_pkg::ADDR_W-1:0] wr_addr;

   logic                        out_free;
   logic                        emit;
   logic                        emit_ok;
   spsc_pkg::item_type          emit_item;

   assign out_free        = !out_valid_ff || rsp_pop;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_still_valid = out_still_ff;
   assign rsp_done_res    = out_done_ff;
   assign rsp_count_error = out_cerr_ff;
   assign rd_addr         = depth_ff - spsc_pkg::ADDR_W'(2);
   assign wr_addr         = depth_ff - spsc_pkg::ADDR_W'(1);

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      next_in      = next_ff;
      top_in       = top_ff;
      failed_in    = failed_ff;
      item_in      = item_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_still_in = out_still_ff;
      out_done_in  = out_done_ff;
      out_cerr_in  = out_cerr_ff;
      q_rd_en      = 1'b0;
      wr_en        = 1'b0;
      emit         = 1'b0;
      emit_ok      = 1'b0;
      emit_item    = q_item;

      unique case (state_ff)
         ST_DECIDE: begin
            if (!q_empty && out_free) begin
               q_rd_en = 1'b1;
               if (failed_ff || q_item.bad_range) begin
                  emit = 1'b1;
               end else if (q_item.element >= next_ff) begin
                  if (next_ff < q_item.element) begin
                     item_in  = q_item;
                     state_in = ST_PUSH;
                  end else begin
                     next_in = q_item.element + spsc_pkg::VAL_W'(1);
                     emit    = 1'b1;
                     emit_ok = 1'b1;
                  end
               end else if (depth_ff != '0 && top_ff == q_item.element) begin
                  depth_in = depth_ff - spsc_pkg::ADDR_W'(1);
                  emit     = 1'b1;
                  emit_ok  = 1'b1;
                  if (!q_item.last && depth_ff > spsc_pkg::ADDR_W'(1)) begin
                     state_in = ST_REFILL;
                  end
               end else begin
                  emit = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            wr_en    = (depth_ff != '0);
            top_in   = next_ff;
            depth_in = depth_ff + spsc_pkg::ADDR_W'(1);
            if (next_ff + spsc_pkg::VAL_W'(1) == item_ff.element) begin
               next_in  = item_ff.element + spsc_pkg::VAL_W'(1);
               state_in = ST_EMIT;
            end else begin
               next_in = next_ff + spsc_pkg::VAL_W'(1);
            end
         end
         ST_EMIT: begin
            emit_item = item_ff;
            if (out_free) begin
               emit     = 1'b1;
               emit_ok  = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_REFILL: begin
            top_in   = rd_data_ff;
            state_in = ST_DECIDE;
         end
         default: begin
            state_in = ST_DECIDE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         out_still_in = emit_ok;
         out_done_in  = emit_item.last;
         out_cerr_in  = emit_item.count_err;
         failed_in    = !emit_ok;
         if (emit_item.last) begin
            depth_in  = '0;
            next_in   = spsc_pkg::VAL_W'(1);
            failed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DECIDE;
         depth_ff     <= '0;
         next_ff      <= spsc_pkg::VAL_W'(1);
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         next_ff      <= next_in;
         failed_ff    <= failed_in;
         out_valid_ff <= out_valid_in;
      end
      top_ff       <= top_in;
      item_ff      <= item_in;
      out_still_ff <= out_still_in;
      out_done_ff  <= out_done_in;
      out_cerr_ff  <= out_cerr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   a_push_below_target: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |-> next_ff < item_ff.element)
      else $error("push run overshoots its target element");

   a_refill_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REFILL |-> $past(state_ff) == ST_DECIDE && $past(q_rd_en))
      else $error("top refill without a preceding pop");

   a_no_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result written over an untaken result");

   a_no_stack_overflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |-> depth_ff != '1)
      else $error("stack overflow");

endmodule

// ===== rtl/core/stack_pop_sequence_check.sv =====
// Top level of the stack pop sequence checker.
//
// channel  ports                                          dir  handshake
// req      req_element[6:0] req_last                      in   req_push & !req_full
// rsp      rsp_still_valid rsp_done_res rsp_count_error   out  rsp_pop & !rsp_empty
// csr      csr_wr_data[6:0] (sequence length n)           in   csr_wr_en
//
// An element that pops the stack while entries remain below the top, and is not the last,
// goes on through ST_REFILL; one that pushes k numbers passes ST_PUSH for each and then
// ST_EMIT. Pushes total at most n-1 per sequence. The stack memory has one write port
// and one registered read port, from which ST_REFILL reloads the top register.
// A two-entry queue parts front and back end; the result register frees on pop.
// Reset is synchronous; it sets n to 1 and empties the queue, stack and result.
module stack_pop_sequence_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [spsc_pkg::VAL_W-1:0] req_element,
   input  logic                       req_last,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_still_valid,
   output logic                       rsp_done_res,
   output logic                       rsp_count_error,
   input  logic                       csr_wr_en,
   input  logic [spsc_pkg::VAL_W-1:0] csr_wr_data
);

   logic               q_full;
   logic               q_empty;
   logic               q_wr_en;
   logic               q_rd_en;
   spsc_pkg::item_type q_wr_item;
   spsc_pkg::item_type q_rd_item;

   spsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_element (req_element),
      .req_last    (req_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_wr_en     (q_wr_en),
      .q_wr_item   (q_wr_item)
   );

   spsc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_item (q_wr_item),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .empty   (q_empty),
      .rd_item (q_rd_item)
   );

   spsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_rd_item),
      .q_rd_en         (q_rd_en),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_still_valid (rsp_still_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_count_error (rsp_count_error)
   );

endmodule
